[hw/rtl/mhpq_pkg.sv]
`timescale 1ns / 1ps

package mhpq_pkg;

  // Default number of entries in the heap store
  localparam int unsigned DefCapacity = 64;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;

  typedef enum logic {
    KindPush = 1'b0,
    KindPop  = 1'b1
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StPushed    = 3'd0,
    StDuplicate = 3'd1,
    StFull      = 3'd2,
    StPopped    = 3'd3,
    StEmpty     = 3'd4
  } status_e;

  // One finished result word, handed from the sequencer to the output register
  typedef struct packed {
    logic signed [ValueW-1:0] popped_value;
    status_e                  status;
    logic [CountW-1:0]        entry_count;
  } res_t;

endpackage

[hw/rtl/mhpq_store.sv]
`timescale 1ns / 1ps

module mhpq_store #(
  parameter int unsigned Depth = mhpq_pkg::DefCapacity,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [mhpq_pkg::ValueW-1:0] wr_data_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [mhpq_pkg::ValueW-1:0] rd_data_o
);
  import mhpq_pkg::*;

  logic [ValueW-1:0] mem [Depth];
  logic [ValueW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read: data appears in the cycle after the address
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/mhpq_ctrl.sv]
`timescale 1ns / 1ps

module mhpq_ctrl #(
  parameter int unsigned Capacity = mhpq_pkg::DefCapacity,
  localparam int unsigned IdxW = $clog2(Capacity)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input word
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [mhpq_pkg::ValueW-1:0] value_i,
  // finished result
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output mhpq_pkg::res_t                     res_o,
  // store port
  output logic                               wr_en_o,
  output logic [IdxW-1:0]                    wr_addr_o,
  output logic [mhpq_pkg::ValueW-1:0]        wr_data_o,
  output logic [IdxW-1:0]                    rd_addr_o,
  input  logic [mhpq_pkg::ValueW-1:0]        rd_data_i
);
  import mhpq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned LW   = IdxW + 2;

  typedef enum logic [3:0] {
    SIdle,
    SScan,
    SUpRd,
    SUpCmp,
    SPopRdl,
    SPopLast,
    SDnRdl,
    SDnRdr,
    SDnCmp,
    SDnDec,
    SDone
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [ValueW-1:0] top_q, top_d;
  logic [ValueW-1:0] lval_q, lval_d;
  logic [ValueW-1:0] bv_q, bv_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   big_q, big_d;
  status_e           status_q, status_d;

  logic [IdxW-1:0] parent;
  logic [LW-1:0]   left_w, right_w, cnt_ext;

  assign parent  = (pos_q - IdxW'(1)) >> 1;
  assign left_w  = {1'b0, pos_q, 1'b1};
  assign right_w = left_w + LW'(1);
  assign cnt_ext = LW'(cnt_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    cmp_vld_d = cmp_vld_q;
    val_d     = val_q;
    top_d     = top_q;
    lval_d    = lval_q;
    bv_d      = bv_q;
    pos_d     = pos_q;
    big_d     = big_q;
    status_d  = status_q;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = pos_q;
    wr_data_o = val_q;

    case (state_q)
      SIdle: begin
        // root is read speculatively so a pop finds it next cycle
        if (in_valid_i) begin
          val_d     = value_i;
          top_d     = '0;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          if (kind_i == KindPop) begin
            if (cnt_q == '0) begin
              status_d = StEmpty;
              state_d  = SDone;
            end else begin
              state_d = SPopRdl;
            end
          end else begin
            state_d = SScan;
          end
        end
      end

      SScan: begin
        if (cmp_vld_q && (rd_data_i == val_q)) begin
          status_d  = StDuplicate;
          cmp_vld_d = 1'b0;
          state_d   = SDone;
        end else if (idx_q < cnt_q) begin
          rd_addr_o = idx_q[IdxW-1:0];
          idx_d     = idx_q + CntW'(1);
          cmp_vld_d = 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
          if (cnt_q == CntW'(Capacity)) begin
            status_d = StFull;
            state_d  = SDone;
          end else begin
            pos_d   = cnt_q[IdxW-1:0];
            cnt_d   = cnt_q + CntW'(1);
            state_d = SUpRd;
          end
        end
      end

      SUpRd: begin
        if (pos_q == '0) begin
          wr_en_o  = 1'b1;
          status_d = StPushed;
          state_d  = SDone;
        end else begin
          rd_addr_o = parent;
          state_d   = SUpCmp;
        end
      end

      SUpCmp: begin
        // move the parent down into the hole, or drop the new value here
        wr_en_o = 1'b1;
        if ($signed(val_q) > $signed(rd_data_i)) begin
          wr_data_o = rd_data_i;
          pos_d     = parent;
          state_d   = SUpRd;
        end else begin
          status_d = StPushed;
          state_d  = SDone;
        end
      end

      SPopRdl: begin
        top_d     = rd_data_i;
        cnt_d     = cnt_q - CntW'(1);
        rd_addr_o = IdxW'(cnt_q - CntW'(1));
        state_d   = SPopLast;
      end

      SPopLast: begin
        val_d   = rd_data_i;
        pos_d   = '0;
        state_d = SDnRdl;
      end

      SDnRdl: begin
        if (left_w >= cnt_ext) begin
          wr_en_o  = 1'b1;
          status_d = StPopped;
          state_d  = SDone;
        end else begin
          rd_addr_o = left_w[IdxW-1:0];
          state_d   = SDnRdr;
        end
      end

      SDnRdr: begin
        lval_d = rd_data_i;
        if (right_w < cnt_ext) begin
          rd_addr_o = right_w[IdxW-1:0];
          state_d   = SDnCmp;
        end else begin
          big_d   = left_w[IdxW-1:0];
          bv_d    = rd_data_i;
          state_d = SDnDec;
        end
      end

      SDnCmp: begin
        // left child wins ties
        if ($signed(rd_data_i) > $signed(lval_q)) begin
          big_d = right_w[IdxW-1:0];
          bv_d  = rd_data_i;
        end else begin
          big_d = left_w[IdxW-1:0];
          bv_d  = lval_q;
        end
        state_d = SDnDec;
      end

      SDnDec: begin
        wr_en_o = 1'b1;
        if ($signed(bv_q) > $signed(val_q)) begin
          wr_data_o = bv_q;
          pos_d     = big_q;
          state_d   = SDnRdl;
        end else begin
          status_d = StPopped;
          state_d  = SDone;
        end
      end

      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      status_q  <= StPushed;
      val_q     <= '0;
      top_q     <= '0;
      lval_q    <= '0;
      bv_q      <= '0;
      pos_q     <= '0;
      big_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      status_q  <= status_d;
      val_q     <= val_d;
      top_q     <= top_d;
      lval_q    <= lval_d;
      bv_q      <= bv_d;
      pos_q     <= pos_d;
      big_q     <= big_d;
    end
  end

  assign in_ready_o          = (state_q == SIdle);
  assign res_valid_o         = (state_q == SDone);
  assign res_o.popped_value  = top_q;
  assign res_o.status        = status_q;
  assign res_o.entry_count   = CountW'(cnt_q);

endmodule

[hw/rtl/max_heap_priority_queue_top.sv]
`timescale 1ns / 1ps

// Binary max-heap priority queue of up to CAPACITY signed 32-bit values.
// A push word (kind 0) first scans every live entry for an equal value and is
// ignored if one is found (status 1), also when the store is full; a new value
// into a full store is ignored with status 2; otherwise the value is appended
// and sifted up (status 0). A pop word (kind 1) returns the maximum (status 3)
// and sifts the last entry down from the root; a pop of an empty heap returns
// zero with status 4. Every word gives exactly one result word, carrying the
// popped value (zero unless popped), the status and the entry count afterwards.
// The heap lives in a single-port-read, single-port-write memory with a
// registered read, and each step of the work makes at most one read and one
// write. A push reads the live entries one by one, stopping early on a
// duplicate, then climbs level by level, reading the parent and then writing
// one slot. A pop uses the root read while idle, reads the last entry, then
// for each level reads the left child and, if present, the right child, picks
// the larger and writes one slot. An empty pop goes straight to its result.
// The result then passes to a free output register and the sequencer returns
// to idle before it takes the next word. The next word is taken as soon as
// the sequencer has handed its result to the output register, even while that
// result still waits for the consumer.

module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = mhpq_pkg::DefCapacity
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [mhpq_pkg::ValueW-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mhpq_pkg::ValueW-1:0] popped_value_o,
  output logic [mhpq_pkg::StatusW-1:0]       status_o,
  output logic [mhpq_pkg::CountW-1:0]        entry_count_o
);
  import mhpq_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [ValueW-1:0] wr_data;
  logic [IdxW-1:0]   rd_addr;
  logic [ValueW-1:0] rd_data;

  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  // Heap sequencer: scan, sift up, sift down; it works on one word at a time
  mhpq_ctrl #(
    .Capacity(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  // Heap storage; contents are undefined until written
  mhpq_store #(
    .Depth(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Output register: take a new result when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload while the word waits
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_res_q.popped_value;
  assign status_o       = out_res_q.status;
  assign entry_count_o  = out_res_q.entry_count;

endmodule

[verif/heap_check_pkg.sv]
`timescale 1ns / 1ps

package heap_check_pkg;
  import mhpq_pkg::*;

  class heap_checker;
    logic [ValueW-1:0] shadow_heap [DefCapacity];
    int unsigned       shadow_count;
    int unsigned       peak_count;
    res_t              awaited_replies [$];
    int unsigned       mismatches;
    int unsigned       failures;
    int unsigned       replies_checked;
    int unsigned       status_tally [5];

    function new();
      shadow_count    = 0;
      peak_count      = 0;
      mismatches      = 0;
      failures        = 0;
      replies_checked = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function bit above(logic [ValueW-1:0] a, logic [ValueW-1:0] b);
      return $signed(a) > $signed(b);
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [ValueW-1:0] t;
      t              = shadow_heap[a];
      shadow_heap[a] = shadow_heap[b];
      shadow_heap[b] = t;
    endfunction

    function res_t predict_push(logic [ValueW-1:0] v);
      res_t        r;
      int unsigned i;
      r.popped_value = '0;
      for (i = 0; i < shadow_count; i++) begin
        if (shadow_heap[i] == v) begin
          r.status      = StDuplicate;
          r.entry_count = CountW'(shadow_count);
          return r;
        end
      end
      if (shadow_count >= DefCapacity) begin
        r.status      = StFull;
        r.entry_count = CountW'(shadow_count);
        return r;
      end
      i              = shadow_count;
      shadow_heap[i] = v;
      shadow_count++;
      if (shadow_count > peak_count) peak_count = shadow_count;
      while (i > 0 && above(shadow_heap[i], shadow_heap[(i - 1) / 2])) begin
        swap_slots(i, (i - 1) / 2);
        i = (i - 1) / 2;
      end
      r.status      = StPushed;
      r.entry_count = CountW'(shadow_count);
      return r;
    endfunction

    function res_t predict_pop();
      res_t        r;
      int unsigned i;
      int unsigned big;
      r.popped_value = '0;
      if (shadow_count == 0) begin
        r.status      = StEmpty;
        r.entry_count = '0;
        return r;
      end
      r.popped_value = shadow_heap[0];
      shadow_count--;
      shadow_heap[0] = shadow_heap[shadow_count];
      i = 0;
      while (2 * i + 1 < shadow_count) begin
        big = 2 * i + 1;
        if (big + 1 < shadow_count && above(shadow_heap[big + 1], shadow_heap[big])) big++;
        if (!above(shadow_heap[big], shadow_heap[i])) break;
        swap_slots(i, big);
        i = big;
      end
      r.status      = StPopped;
      r.entry_count = CountW'(shadow_count);
      return r;
    endfunction

    function void note_request(kind_e k, logic [ValueW-1:0] v);
      res_t r;
      if (k == KindPush) r = predict_push(v);
      else r = predict_pop();
      awaited_replies = {awaited_replies, r};
    endfunction

    function void check_reply(logic [ValueW-1:0] popped, logic [StatusW-1:0] status,
                              logic [CountW-1:0] count);
      res_t want;
      if (awaited_replies.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: popped %0d status %0d count %0d",
                   $signed(popped), status, count);
        return;
      end
      want = awaited_replies.pop_front();
      replies_checked++;
      status_tally[want.status]++;
      if (popped !== want.popped_value || status !== want.status ||
          count !== want.entry_count) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display({"reply %0d: popped exp %0d got %0d, status exp %0d got %0d,",
                    " count exp %0d got %0d"},
                   replies_checked, $signed(want.popped_value), $signed(popped),
                   want.status, status, want.entry_count, count);
      end
    endfunction

    function int unsigned pending();
      return awaited_replies.size();
    endfunction

    function int unsigned live();
      return shadow_count;
    endfunction

    function logic [ValueW-1:0] pick_stored();
      if (shadow_count == 0) return $urandom;
      return shadow_heap[$urandom_range(shadow_count - 1)];
    endfunction

    function void close_out();
      if (awaited_replies.size() != 0) begin
        $display("%0d replies never arrived", awaited_replies.size());
        failures += awaited_replies.size();
      end
    endfunction
  endclass

endpackage

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mhpq_pkg::*;
  import heap_check_pkg::*;

  localparam int unsigned Capacity    = DefCapacity;
  localparam int unsigned RandomWords = 500;
  // Well above the slowest word and the long consumer hold-off.
  localparam int unsigned IdleLimit   = 4000;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic                     kind_i         = 1'b0;
  logic signed [ValueW-1:0] value_i        = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [ValueW-1:0] popped_value_o;
  logic [StatusW-1:0]       status_o;
  logic [CountW-1:0]        entry_count_o;

  heap_checker heap_sb = new();
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  bit          draining   = 1'b0;

  max_heap_priority_queue_top #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Offer one word at the falling edge and hold it until the block takes it.
  // The sender runs in bursts; between bursts insert a random gap, sometimes none.
  task automatic offer_word(input kind_e k, input logic [ValueW-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i = 1'b1;
    kind_i     = k;
    value_i    = v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    heap_sb.note_request(k, v);
    words_sent++;
    burst_left--;
    @(negedge clk_i);
    // Drop valid; a following word in the same burst raises it again at once.
    in_valid_i = 1'b0;
  endtask

  task automatic push_value(input logic [ValueW-1:0] v);
    offer_word(KindPush, v);
  endtask

  // The value field is ignored on a pop, so fill it with noise.
  task automatic pop_max();
    offer_word(KindPop, $urandom);
  endtask

  // Hold the sender until every outstanding reply has come back.
  task automatic wait_drained();
    draining = 1'b1;
    while (heap_sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
    draining = 1'b0;
  endtask

  // Bias values towards ones already stored (to provoke duplicates), a tight
  // band around zero, and the signed extremes.
  function automatic logic [ValueW-1:0] draw_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = heap_sb.pick_stored();
      4, 5:       v = ValueW'($urandom_range(16)) - ValueW'(8);
      6: begin
        case ($urandom_range(3))
          0:       v = {1'b1, {(ValueW-1){1'b0}}};
          1:       v = {1'b0, {(ValueW-1){1'b1}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // Check every reply the consumer takes, sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      heap_sb.check_reply(popped_value_o, status_o, entry_count_o);
  end

  // Consumer: switch between stall patterns in segments of random length.
  // Twice, hold off for a long stretch so the block backs up into its input;
  // start a hold only while the sender is still offering words.
  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned holds_done;
    seg_left   = 0;
    mode       = 0;
    hold_left  = 0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (holds_done < 2 && !draining &&
                   heap_sb.replies_checked >= 120 + holds_done * 240) begin
        out_ready_i = 1'b0;
        hold_left   = 400;
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(3);
          seg_left = $urandom_range(4, 60);
        end
        seg_left--;
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = 1'($urandom_range(1));
          2:       out_ready_i = ($urandom_range(3) == 0);
          default: out_ready_i = ~out_ready_i;
        endcase
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("timeout: no word moved for %0d cycles", IdleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned tries;
    int unsigned directed_words;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty pop, signed extremes, duplicates, pops in order.
    pop_max();
    push_value({1'b0, {(ValueW-1){1'b1}}});
    push_value({1'b1, {(ValueW-1){1'b0}}});
    push_value('0);
    push_value('1);
    push_value(ValueW'(1));
    push_value({1'b1, {(ValueW-1){1'b0}}});
    push_value({1'b0, {(ValueW-1){1'b1}}});
    push_value('0);
    repeat (5) pop_max();
    pop_max();
    push_value(32'h5555_5555);
    push_value(32'haaaa_aaaa);
    pop_max();
    pop_max();
    // Pause the sender until the block has answered everything.
    wait_drained();
    directed_words = words_sent;

    // Random phases: fill to capacity and poke at a full store, drain past
    // empty, or a mixed run leaning towards pushes.
    while (words_sent < directed_words + RandomWords) begin
      phase = $urandom_range(9);
      if (phase < 2) begin
        tries = 0;
        while (heap_sb.live() < Capacity && tries < 200) begin
          push_value($urandom);
          tries++;
        end
        push_value($urandom);
        push_value(heap_sb.pick_stored());
        push_value(draw_value());
      end else if (phase < 4) begin
        n = heap_sb.live() + 2;
        repeat (n) pop_max();
      end else begin
        n = $urandom_range(10, 40);
        repeat (n) begin
          if ($urandom_range(9) < 6) push_value(draw_value());
          else pop_max();
        end
      end
      if ($urandom_range(4) == 0) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    heap_sb.close_out();

    $display("Sent %0d words, checked %0d replies (%0d mismatching).",
             words_sent, heap_sb.replies_checked, heap_sb.mismatches);
    $display({"Replies: %0d pushed, %0d duplicate, %0d full, %0d popped,",
              " %0d empty; peak %0d of %0d."},
             heap_sb.status_tally[StPushed], heap_sb.status_tally[StDuplicate],
             heap_sb.status_tally[StFull], heap_sb.status_tally[StPopped],
             heap_sb.status_tally[StEmpty], heap_sb.peak_count, Capacity);
    if (heap_sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
